@@ rtl/sssp_pkg.sv @@
// Package for the shortest path block: payload structs, constants, helpers.
// No dependencies.
package sssp_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef struct packed {
    logic [5:0]         edge_from;
    logic [5:0]         edge_to;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         vertex_id;
    logic signed [31:0] distance;
    logic               unreachable;
    logic [5:0]         predecessor;
    logic               predecessor_valid;
    logic               last_vertex;
  } out_item_t;

  // Edge as it travels from the front part to the back part.
  typedef struct packed {
    logic [5:0]         src;
    logic [5:0]         dst;
    logic signed [23:0] wt;
    logic               store;
    logic               last;
  } edge_cmd_t;
endpackage

@@ rtl/sssp_front.sv @@
// Front part: takes edge items, sign-extends the weight, decides whether the
// edge is stored, and pushes a command into a two-entry queue. Uses sssp_pkg.
module sssp_front #(
  parameter int MAX_EDGES   = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF,
  parameter int EC_W        = $clog2(MAX_EDGES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  sssp_pkg::in_item_t  in_item,
  input  logic                run_done,
  output logic                fr_busy,
  output logic                q_valid,
  output sssp_pkg::edge_cmd_t q_cmd,
  input  logic                q_pop
);
  import sssp_pkg::*;

  edge_cmd_t      q_r [2];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           rd_r;
  logic [EC_W-1:0] fill_r;
  logic           hold_r;   // run in flight: accept nothing until done
  edge_cmd_t      cmd;
  logic           push;

  assign fr_busy = hold_r || (cnt_r == 2'd2);
  assign push    = in_start && !fr_busy;

  always_comb begin
    cmd.src   = in_item.edge_from;
    cmd.dst   = in_item.edge_to;
    cmd.wt    = 24'(signed'(in_item.edge_weight[WEIGHT_BITS-1:0]));
    cmd.store = (fill_r < EC_W'(MAX_EDGES));
    cmd.last  = in_item.last_edge;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rd_r   <= 1'b0;
      fill_r <= '0;
      hold_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_pop) rd_r <= !rd_r;
      if (push) begin
        if (in_item.last_edge) begin
          fill_r <= '0;
          hold_r <= 1'b1;
        end else if (cmd.store) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (run_done) hold_r <= 1'b0;
    end
    // write slot is the head when empty, else the one after it; a full queue never pushes
    if (push) q_r[rd_r ^ (cnt_r != 2'd0)] <= cmd;
  end
endmodule

@@ rtl/sssp_back.sv @@
// Back part: edge memory, distance tables and the relaxation/readout
// sequencer. Uses sssp_pkg; fed by sssp_front.
module sssp_back #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF,
  parameter int EA_W         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int EC_W         = $clog2(MAX_EDGES + 1),
  parameter int VA_W         = $clog2(MAX_VERTICES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          vertex_count,
  input  logic [5:0]          source_vertex,
  input  logic                q_valid,
  input  sssp_pkg::edge_cmd_t q_cmd,
  output logic                q_pop,
  output logic                run_done,
  output logic                out_strobe,
  output sssp_pkg::out_item_t out_item
);
  import sssp_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_INIT  = 6'b000010,
    S_RD    = 6'b000100,
    S_RELAX = 6'b001000,
    S_PASS  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r;
  logic [28+6+6-1:0] emem [MAX_EDGES];   // {wt, pad, src, dst} (wt in 39-16)
  logic signed [31:0] dist_m [MAX_VERTICES];
  logic [VA_W-1:0]    pred_m [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reach_r, pok_r;

  logic [EC_W-1:0] ecnt_r;
  logic [EC_W-1:0] k_r;
  logic [6:0]      pass_r, n_r, v_r;
  logic            chg_r;
  logic [39:0]     erd_r;
  logic            erd_v_r;
  logic signed [31:0] da_r, db_r;
  logic            s_pipe_r;

  // Stage 1: edge read. Stage 2: distance reads. Stage 3: compare/write.
  logic [5:0] ea, eb;
  logic signed [23:0] ew;
  assign ew = erd_r[39:16];
  assign ea = erd_r[11:6];
  assign eb = erd_r[5:0];

  logic ok2;
  logic signed [32:0] sum;
  logic signed [31:0] cand;
  logic upd;
  always_comb begin
    ok2  = erd_v_r && (7'(ea) < n_r) && (7'(eb) < n_r) && reach_r[ea[VA_W-1:0]];
    sum  = 33'(da_r) + 33'(ew);
    if (sum > 33'(INT_MAX))      cand = INT_MAX;
    else if (sum < 33'(INT_MIN)) cand = INT_MIN;
    else                         cand = sum[31:0];
    upd  = ok2 && (!reach_r[eb[VA_W-1:0]] || cand < db_r);
  end

  logic [6:0] nsel;
  always_comb begin
    nsel = vertex_count;
    if (nsel == 7'd0) nsel = 7'd1;
    if (nsel > 7'(MAX_VERTICES)) nsel = 7'(MAX_VERTICES);
  end

  assign q_pop = (state_r == S_LOAD) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      ecnt_r     <= '0;
      run_done   <= 1'b0;
      out_strobe <= 1'b0;
      erd_v_r    <= 1'b0;
      reach_r    <= '0;
      pok_r      <= '0;
    end else begin
      out_strobe <= (state_r == S_OUT);
      run_done   <= (state_r == S_OUT) && (v_r + 7'd1 == n_r);
      unique case (state_r)
        S_LOAD: if (q_pop) begin
          if (q_cmd.store) begin
            emem[ecnt_r[EA_W-1:0]] <= {q_cmd.wt, 4'd0, q_cmd.src, q_cmd.dst};
            ecnt_r <= ecnt_r + 1'b1;
          end
          if (q_cmd.last) begin
            n_r     <= nsel;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          reach_r <= (7'(source_vertex) < n_r)
                     ? ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << source_vertex[VA_W-1:0])
                     : '0;
          pok_r   <= '0;
          if (7'(source_vertex) < n_r) begin
            dist_m[source_vertex[VA_W-1:0]]  <= '0;
          end
          pass_r  <= 7'd0;
          k_r     <= '0;
          chg_r   <= 1'b0;
          v_r     <= '0;
          state_r <= (n_r > 7'd1) ? S_RD : S_OUT;
        end
        S_RD: begin
          // one edge at a time, in order: read edge, read distances, write
          erd_r   <= emem[k_r[EA_W-1:0]];
          erd_v_r <= 1'b1;
          state_r <= S_RELAX;
          s_pipe_r <= 1'b0;
        end
        S_RELAX: begin
          if (!s_pipe_r) begin
            da_r     <= dist_m[ea[VA_W-1:0]];
            db_r     <= dist_m[eb[VA_W-1:0]];
            s_pipe_r <= 1'b1;
          end else begin
            if (upd) begin
              dist_m[eb[VA_W-1:0]] <= cand;
              pred_m[eb[VA_W-1:0]] <= ea[VA_W-1:0];
              reach_r[eb[VA_W-1:0]] <= 1'b1;
              pok_r[eb[VA_W-1:0]]   <= 1'b1;
              chg_r <= 1'b1;
            end
            erd_v_r <= 1'b0;
            k_r     <= k_r + 1'b1;
            state_r <= (k_r + 1'b1 >= ecnt_r) ? S_PASS : S_RD;
          end
        end
        S_PASS: begin
          k_r    <= '0;
          chg_r  <= 1'b0;
          pass_r <= pass_r + 1'b1;
          state_r <= (!chg_r || pass_r + 7'd2 >= n_r) ? S_OUT : S_RD;
        end
        S_OUT: begin
          out_item.vertex_id   <= v_r[5:0];
          out_item.unreachable <= !reach_r[v_r[VA_W-1:0]];
          out_item.distance    <= reach_r[v_r[VA_W-1:0]] ? dist_m[v_r[VA_W-1:0]] : INT_MAX;
          out_item.predecessor_valid <= pok_r[v_r[VA_W-1:0]];
          out_item.predecessor <= pok_r[v_r[VA_W-1:0]] ? 6'(pred_m[v_r[VA_W-1:0]]) : 6'd0;
          out_item.last_vertex <= (v_r + 7'd1 == n_r);
          v_r <= v_r + 7'd1;
          if (v_r + 7'd1 == n_r) begin
            state_r  <= S_LOAD;
            ecnt_r   <= '0;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ rtl/single_source_shortest_path.sv @@
// Top level of the shortest path block: configuration registers, front part
// and back part. Uses sssp_pkg, sssp_front, sssp_back.
//
//  channel | direction | handshake            | payload
//  in_     | in        | start / busy         | in_item  (edge, weight, last)
//  out_    | out       | out_strobe           | out_item (one vertex)
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Edges are taken one a cycle while busy is low into a two-entry queue and
// written to the edge memory at one a cycle. After the last edge the
// relaxation walk makes up to vertex_count-1 passes over the stored edges
// (edge memory read, distance reads, update), then one result a cycle.
// busy stays high from the last edge until the final result. Reset is
// synchronous, active low; the result side cannot stall.
module single_source_shortest_path #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sssp_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output sssp_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);
  import sssp_pkg::*;

  localparam int EC_W = $clog2(MAX_EDGES + 1);

  logic [6:0] vcnt_r;
  logic [5:0] src_r;
  logic       q_valid, q_pop, run_done;
  edge_cmd_t  q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= 7'd64;
      src_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vcnt_r <= cfg_data;
        CFG_SOURCE_VERTEX: src_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  sssp_front #(.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS), .EC_W(EC_W)) u_front (
    .clk, .rst_n, .in_start(start), .in_item, .run_done,
    .fr_busy(busy), .q_valid, .q_cmd, .q_pop
  );

  sssp_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .EC_W(EC_W)) u_back (
    .clk, .rst_n, .vertex_count(vcnt_r), .source_vertex(src_r),
    .q_valid, .q_cmd, .q_pop, .run_done, .out_strobe, .out_item
  );
endmodule

@@ verif/single_source_shortest_path_tb.sv @@
// Testbench for single_source_shortest_path: loads edge runs, predicts the
// per-vertex distances and checks every result. Depends on rtl/sssp_pkg.sv
// and rtl/single_source_shortest_path.sv.
module single_source_shortest_path_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sssp_pkg::*;

  localparam int NV        = MAX_VERTICES_DEF;
  localparam int NE        = MAX_EDGES_DEF;
  localparam int IDLE_LIMIT = 50000;   // cycles with no handshake at all

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [6:0] cfg_data;

  single_source_shortest_path dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: config registers and the stored edge list.
  // ---------------------------------------------------------------------
  logic [6:0]  vc_reg;
  logic [5:0]  src_reg;
  logic [5:0]  edge_tail [NE];
  logic [5:0]  edge_head [NE];
  int          edge_wt   [NE];
  int          edges_held;

  out_item_t   vertex_expected [$];

  int errors;
  int items_sent;
  int runs_done;
  int results_seen;
  int burst_left;

  // Relax the held edges from the source and queue one result per vertex.
  task automatic solve_paths();
    int          n;
    longint      dist_v [NV];
    bit          reach [NV];
    logic [5:0]  pred [NV];
    bit          pred_ok [NV];
    bit          changed;
    longint      cand;
    int          a, b;
    out_item_t   r;
    n = (vc_reg == 0) ? 1 : ((vc_reg > NV) ? NV : int'(vc_reg));
    for (int k = 0; k < NV; k++) begin
      dist_v[k] = INT_MAX; reach[k] = 0; pred[k] = '0; pred_ok[k] = 0;
    end
    if (src_reg < n) begin
      dist_v[src_reg] = 0;
      reach[src_reg] = 1;
    end
    for (int p = 0; p + 1 < n; p++) begin
      changed = 0;
      for (int k = 0; k < edges_held; k++) begin
        a = edge_tail[k];
        b = edge_head[k];
        if (a >= n || b >= n || !reach[a]) continue;
        cand = dist_v[a] + longint'(edge_wt[k]);
        if (cand > longint'(INT_MAX)) cand = INT_MAX;
        if (cand < longint'(INT_MIN)) cand = INT_MIN;
        if (!reach[b] || cand < dist_v[b]) begin
          dist_v[b] = cand; reach[b] = 1; pred[b] = a[5:0]; pred_ok[b] = 1;
          changed = 1;
        end
      end
      if (!changed) break;
    end
    for (int k = 0; k < n; k++) begin
      r.vertex_id         = k[5:0];
      r.distance          = reach[k] ? 32'(dist_v[k]) : INT_MAX;
      r.unreachable       = !reach[k];
      r.predecessor       = pred_ok[k] ? pred[k] : 6'd0;
      r.predecessor_valid = pred_ok[k];
      r.last_vertex       = (k + 1 == n);
      vertex_expected.insert(vertex_expected.size(), r);
    end
  endtask

  // Accepted edge: store it (dropped once the store is full), solve on last.
  task automatic take_edge(input in_item_t it);
    if (edges_held < NE) begin
      edge_tail[edges_held] = it.edge_from;
      edge_head[edges_held] = it.edge_to;
      edge_wt[edges_held]   = int'(it.edge_weight);
      edges_held++;
    end
    if (it.last_edge) begin
      solve_paths();
      edges_held = 0;
      runs_done++;
    end
  endtask

  // Drive one edge from a falling edge; returns at the falling edge after
  // it was taken, with start still high so bursts run back to back.
  task automatic send_edge(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      start = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start   = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    take_edge(it);
    // directed rows with a hand-written result replace the predicted one
    if (typed) begin
      vertex_expected[vertex_expected.size() - 1] = want;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Let the block drain fully before touching the registers.
  task automatic settle();
    start = 1'b0;
    while (vertex_expected.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] val);
    start     = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_VERTEX_COUNT) vc_reg = val;
    else src_reg = val[5:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every strobe is matched with the oldest expectation.
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  int idle_cycles;

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (vertex_expected.size() == 0) begin
        $error("result for vertex %0d with nothing expected", out_item.vertex_id);
        errors++;
      end else begin
        w = vertex_expected.pop_front();
        check_field("vertex_id", w.vertex_id, out_item.vertex_id);
        check_field("distance", w.distance, out_item.distance);
        check_field("unreachable", w.unreachable, out_item.unreachable);
        check_field("predecessor", w.predecessor, out_item.predecessor);
        check_field("predecessor_valid", w.predecessor_valid,
                    out_item.predecessor_valid);
        check_field("last_vertex", w.last_vertex, out_item.last_vertex);
      end
    end
    // watchdog: any handshake on any channel counts as progress
    if (!rst_n || out_strobe || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table. A row may first set both registers (only at the start
  // of a run). Rows with vertex_count 0 or 1 carry their single result by hand.
  // ---------------------------------------------------------------------
  typedef struct {
    bit         do_cfg;
    logic [6:0] vc;
    logic [5:0] sv;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } edge_row_t;

  edge_row_t plan [$];

  task automatic add_row(input bit do_cfg, input int vc, input int sv,
                         input int f, input int t, input int w, input bit last,
                         input bit typed = 0, input out_item_t want = '0);
    edge_row_t r;
    r.do_cfg = do_cfg; r.vc = vc[6:0]; r.sv = sv[5:0];
    r.item.edge_from = f[5:0]; r.item.edge_to = t[5:0];
    r.item.edge_weight = w[15:0]; r.item.last_edge = last;
    r.typed = typed; r.want = want;
    plan.insert(plan.size(), r);
  endtask

  initial begin
    in_item_t  it;
    int        n_use, n_edges;
    bit        wild;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = CFG_VERTEX_COUNT; cfg_data = '0;
    vc_reg = 7'd64; src_reg = '0; edges_held = 0;
    errors = 0; items_sent = 0; runs_done = 0; results_seen = 0;
    burst_left = 0; idle_cycles = 0;

    // single vertex: no passes, the source reports itself
    add_row(1, 1, 0, 0, 0, 0, 1, 1, '{6'd0, 32'sd0, 1'b0, 6'd0, 1'b0, 1'b1});
    // source beyond vertex_count: nothing reachable
    add_row(1, 1, 5, 63, 63, -32768, 1, 1, '{6'd0, INT_MAX, 1'b1, 6'd0, 1'b0, 1'b1});
    // vertex_count 0 behaves as 1
    add_row(1, 0, 0, 0, 1, 32767, 1, 1, '{6'd0, 32'sd0, 1'b0, 6'd0, 1'b0, 1'b1});
    // vertex_count above the maximum, source at the top vertex
    add_row(1, 127, 63, 0, 63, 5, 0);
    add_row(0, 0, 0, 63, 0, -32768, 0);
    add_row(0, 0, 0, 0, 1, 32767, 0);
    add_row(0, 0, 0, 0, 0, 0, 1);
    // negative cycle through the source, plus extreme weights downstream
    add_row(1, 4, 0, 0, 1, -1, 0);
    add_row(0, 0, 0, 1, 0, -1, 0);
    add_row(0, 0, 0, 1, 2, 32767, 0);
    add_row(0, 0, 0, 2, 3, -32768, 1);
    // edge endpoint out of range is skipped; vertex 2 stays unreachable
    add_row(1, 3, 1, 1, 10, 1, 0);
    add_row(0, 0, 0, 1, 0, 7, 0);
    add_row(0, 0, 0, 10, 2, 1, 1);
    // full size graph, chain in reverse order so many passes are needed
    add_row(1, 64, 0, 2, 3, 100, 0);
    add_row(0, 0, 0, 1, 2, 100, 0);
    add_row(0, 0, 0, 0, 1, 100, 0);
    add_row(0, 0, 0, 0, 3, 500, 1);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].do_cfg) begin
        settle();
        write_cfg(CFG_VERTEX_COUNT, plan[i].vc);
        write_cfg(CFG_SOURCE_VERTEX, {1'b0, plan[i].sv});
      end
      send_edge(plan[i].item, plan[i].typed, plan[i].want);
    end

    // store overflow: more edges than fit, the dropped last one still starts
    settle();
    write_cfg(CFG_VERTEX_COUNT, 7'd2);
    write_cfg(CFG_SOURCE_VERTEX, 7'd0);
    for (int k = 0; k < NE + 6; k++) begin
      it.edge_from   = 6'd0;
      it.edge_to     = 6'd1;
      it.edge_weight = (k == NE + 5) ? -16'sd30000 : 16'($urandom_range(0, 999));
      it.last_edge   = (k == NE + 5);
      send_edge(it, 0, '0);
    end

    // random runs: mostly well-formed small graphs, a few wild ones
    items_sent = 0;
    while (items_sent < 200) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_cfg(CFG_VERTEX_COUNT, 7'd64);
          1:       write_cfg(CFG_VERTEX_COUNT, 7'($urandom_range(0, 127)));
          2, 3:    write_cfg(CFG_VERTEX_COUNT, 7'($urandom_range(9, 63)));
          default: write_cfg(CFG_VERTEX_COUNT, 7'($urandom_range(1, 8)));
        endcase
        n_use = (vc_reg == 0) ? 1 : ((vc_reg > NV) ? NV : int'(vc_reg));
        if ($urandom_range(0, 7) == 0)
          write_cfg(CFG_SOURCE_VERTEX, 7'($urandom_range(0, 63)));
        else
          write_cfg(CFG_SOURCE_VERTEX, 7'($urandom_range(0, n_use - 1)));
      end
      n_use   = (vc_reg == 0) ? 1 : ((vc_reg > NV) ? NV : int'(vc_reg));
      n_edges = $urandom_range(1, 12);
      for (int k = 0; k < n_edges; k++) begin
        wild = ($urandom_range(0, 9) == 0);
        it.edge_from   = wild ? 6'($urandom) : 6'($urandom_range(0, n_use - 1));
        it.edge_to     = wild ? 6'($urandom) : 6'($urandom_range(0, n_use - 1));
        it.edge_weight = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 250) - 50);
        it.last_edge   = (k == n_edges - 1);
        send_edge(it, 0, '0);
      end
    end

    settle();
    repeat (20) @(negedge clk);
    $display("covered %0d graph runs, %0d vertex results checked", runs_done, results_seen);
    $display("register extremes, store overflow and random graphs up to 64 vertices");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
